// ----- sv/lfb_pkg.sv -----
// Shared types and constants for the LED controller frame builder.
package lfb_pkg;

   localparam int BANK_POSITIONS_DEF = 8;
   localparam int LED_POSITIONS_DEF  = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_COUNT       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_BANK_FIRST = 1'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int MODE_W      = 3;

   localparam logic [MODE_W-1:0] MODE_SOLID         = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BREATH_FAST   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BREATH_MEDIUM = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BREATH_SLOW   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RAINBOW       = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RAINBOW_MULTI = 3'd6;

   localparam logic [3:0] FX_BREATH        = 4'd1;
   localparam logic [3:0] FX_BREATH_SPEED  = 4'd2;
   localparam logic [3:0] FX_BREATH_LONG   = 4'd3;
   localparam logic [3:0] FX_STATIC        = 4'd4;
   localparam logic [3:0] FX_PULSE_FAST    = 4'd5;
   localparam logic [3:0] FX_PULSE_MEDIUM  = 4'd6;
   localparam logic [3:0] FX_PULSE_SLOW    = 4'd7;
   localparam logic [3:0] FX_RAINBOW       = 4'd8;
   localparam logic [3:0] FX_RAINBOW_MULTI = 4'd9;

   typedef enum logic [1:0] {
      KIND_SOLID,
      KIND_BREATH,
      KIND_RAINBOW
   } lfb_kind_type;

   typedef struct packed {
      logic              empty;
      logic              force_clear;
      lfb_kind_type      kind;
      logic [MODE_W-1:0] mode;
      logic [7:0]        bright_byte;
      logic [7:0]        rainbow_byte;
      logic [23:0]       col_first;
      logic [23:0]       col_second;
   } lfb_desc_type;

endpackage

// ----- sv/lfb_front.sv -----
// Front end: configuration registers and classification of a request word into a frame descriptor.
module lfb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lfb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [23:0]                        zone0_color,
   input  logic [3:0]                         zone0_effect,
   input  logic [12:0]                        zone0_speed,
   input  logic [6:0]                         zone0_brightness,
   input  logic [23:0]                        zone1_color,
   input  logic [6:0]                         zone1_brightness,
   input  logic                               force_resend,
   output lfb_pkg::lfb_desc_type              desc
);
   import lfb_pkg::*;

   localparam logic [12:0] SPEED_FAST_LIMIT   = 13'd1700;
   localparam logic [12:0] SPEED_MEDIUM_LIMIT = 13'd3300;
   localparam logic [12:0] SPEED_MAX          = 13'd4900;
   localparam logic [6:0]  BRIGHT_MAX         = 7'd100;

   // Scaling by 255/100 and 255/4900 as fixed-point reciprocal products.
   localparam logic [24:0] BRIGHT_SCALE  = 25'd21391185;
   localparam logic [29:0] RAINBOW_SCALE = 30'd894054480;

   logic [1:0]        zone_count_ff;
   logic              right_bank_first_ff;
   logic              two_zones;
   logic [6:0]        b1_used;
   logic [6:0]        bright_max;
   logic [6:0]        bright;
   logic [MODE_W-1:0] mode;
   logic [23:0]       col_a;
   logic [23:0]       col_b;
   logic [12:0]       speed_clamped;
   logic [31:0]       bright_prod;
   logic [42:0]       rainbow_prod;

   function automatic logic [MODE_W-1:0] mode_of(input logic [3:0] effect,
                                                 input logic [12:0] speed);
      logic [MODE_W-1:0] m;
      case (effect)
         FX_BREATH:        m = MODE_BREATH_FAST;
         FX_BREATH_SPEED: begin
            if (speed < SPEED_FAST_LIMIT) m = MODE_BREATH_FAST;
            else if (speed < SPEED_MEDIUM_LIMIT) m = MODE_BREATH_MEDIUM;
            else m = MODE_BREATH_SLOW;
         end
         FX_BREATH_LONG:   m = MODE_BREATH_SLOW;
         FX_STATIC:        m = MODE_SOLID;
         FX_PULSE_FAST:    m = MODE_BREATH_FAST;
         FX_PULSE_MEDIUM:  m = MODE_BREATH_MEDIUM;
         FX_PULSE_SLOW:    m = MODE_BREATH_SLOW;
         FX_RAINBOW:       m = MODE_RAINBOW;
         FX_RAINBOW_MULTI: m = MODE_RAINBOW_MULTI;
         default:          m = MODE_SOLID;
      endcase
      return m;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_count_ff       <= 2'd2;
         right_bank_first_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZONE_COUNT:       zone_count_ff       <= csr_wdata[1:0];
            CSR_RIGHT_BANK_FIRST: right_bank_first_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign two_zones     = zone_count_ff[1];
   assign b1_used       = two_zones ? zone1_brightness : 7'd0;
   assign bright_max    = (b1_used > zone0_brightness) ? b1_used : zone0_brightness;
   assign bright        = (bright_max > BRIGHT_MAX) ? BRIGHT_MAX : bright_max;
   assign mode          = (bright == 7'd0) ? MODE_SOLID : mode_of(zone0_effect, zone0_speed);
   assign col_a         = (bright == 7'd0) ? 24'd0 : zone0_color;
   assign col_b         = ((bright == 7'd0) || !two_zones) ? col_a : zone1_color;
   assign speed_clamped = (zone0_speed > SPEED_MAX) ? SPEED_MAX : zone0_speed;
   assign bright_prod   = 32'(bright) * 32'(BRIGHT_SCALE);
   assign rainbow_prod  = 43'(speed_clamped) * 43'(RAINBOW_SCALE);

   always_comb begin
      desc              = '0;
      desc.empty        = (zone_count_ff == 2'd0);
      desc.force_clear  = force_resend;
      desc.mode         = mode;
      desc.bright_byte  = bright_prod[30:23];
      desc.rainbow_byte = rainbow_prod[41:34];
      if ((mode == MODE_RAINBOW) || (mode == MODE_RAINBOW_MULTI)) begin
         desc.kind       = KIND_RAINBOW;
         desc.col_first  = col_a;
         desc.col_second = col_a;
      end else if (mode == MODE_SOLID) begin
         desc.kind       = KIND_SOLID;
         desc.col_first  = right_bank_first_ff ? col_b : col_a;
         desc.col_second = right_bank_first_ff ? col_a : col_b;
      end else begin
         desc.kind       = KIND_BREATH;
         desc.col_first  = col_a;
         desc.col_second = col_a;
      end
   end

endmodule

// ----- sv/lfb_queue.sv -----
// Short descriptor queue between the front end and the frame sequencer.
module lfb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lfb_pkg::lfb_desc_type push_desc,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output lfb_pkg::lfb_desc_type head
);
   import lfb_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lfb_desc_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_desc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (do_pop) rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ----- sv/lfb_back.sv -----
// Frame sequencer: byte generator, stored last frame, compare pass and emit pass.
module lfb_back #(
   parameter int BANK_POSITIONS = lfb_pkg::BANK_POSITIONS_DEF,
   parameter int LED_POSITIONS  = lfb_pkg::LED_POSITIONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  lfb_pkg::lfb_desc_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_last_byte
);
   import lfb_pkg::*;

   localparam int PAYLOAD_POS = (2 * BANK_POSITIONS > LED_POSITIONS) ?
                                (2 * BANK_POSITIONS) : LED_POSITIONS;
   localparam int FRAME_CAP   = 3 + 3 * PAYLOAD_POS;
   localparam int LEN_W       = $clog2(FRAME_CAP + 1);
   localparam int IDX_W       = $clog2(FRAME_CAP);
   localparam int POS_W       = $clog2(PAYLOAD_POS + 1);
   localparam logic [LEN_W-1:0] LEN_RAINBOW = LEN_W'(6);
   localparam logic [LEN_W-1:0] LEN_SOLID   = LEN_W'(3 + 6 * BANK_POSITIONS);
   localparam logic [LEN_W-1:0] LEN_BREATH  = LEN_W'(3 + 3 * LED_POSITIONS);
   localparam logic [IDX_W-1:0] IDX_MODE    = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_BRIGHT  = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_RB_RATE = IDX_W'(4);
   localparam logic [7:0]       RB_MARK     = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_CMP_END,
      ST_EMIT
   } state_type;

   state_type        state_ff;
   lfb_desc_type     desc_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [POS_W-1:0] pos_ff;
   logic [1:0]       comp_ff;
   logic [7:0]       sum_ff;
   logic [LEN_W-1:0] prev_len_ff;
   logic             cmp_pend_ff;
   logic [7:0]       cmp_byte_ff;
   logic             mismatch_ff;
   logic [7:0]       rd_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic [7:0]       frame_mem [FRAME_CAP];

   logic [LEN_W-1:0] frame_len;
   logic [IDX_W-1:0] last_idx;
   logic             at_last;
   logic [LEN_W-1:0] eff_prev;
   logic [23:0]      colour;
   logic [7:0]       comp_byte;
   logic [7:0]       gen_byte;
   logic             cmp_miss;
   logic             emit_step;

   function automatic logic [LEN_W-1:0] len_of(input lfb_kind_type kind);
      logic [LEN_W-1:0] n;
      case (kind)
         KIND_RAINBOW: n = LEN_RAINBOW;
         KIND_SOLID:   n = LEN_SOLID;
         default:      n = LEN_BREATH;
      endcase
      return n;
   endfunction

   assign frame_len = len_of(desc_ff.kind);
   assign last_idx  = IDX_W'(frame_len - 1'b1);
   assign at_last   = (idx_ff == last_idx);
   assign eff_prev  = q_head.force_clear ? '0 : prev_len_ff;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign cmp_miss  = cmp_pend_ff && (cmp_byte_ff != rd_ff);
   assign emit_step = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      colour = (pos_ff < POS_W'(BANK_POSITIONS)) ? desc_ff.col_first : desc_ff.col_second;
      case (comp_ff)
         2'd0:    comp_byte = colour[23:16];
         2'd1:    comp_byte = colour[15:8];
         default: comp_byte = colour[7:0];
      endcase
      if (idx_ff == IDX_MODE) gen_byte = 8'(desc_ff.mode);
      else if (idx_ff == IDX_BRIGHT) gen_byte = desc_ff.bright_byte;
      else if (at_last) gen_byte = sum_ff;
      else if (desc_ff.kind == KIND_RAINBOW)
         gen_byte = (idx_ff == IDX_RB_RATE) ? desc_ff.rainbow_byte : RB_MARK;
      else gen_byte = comp_byte;
   end

   always_ff @(posedge clock) begin
      if (emit_step) frame_mem[idx_ff] <= gen_byte;
      rd_ff <= frame_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_len_ff  <= '0;
         cmp_pend_ff  <= 1'b0;
         mismatch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_pend_ff  <= (state_ff == ST_CMP);
         rsp_valid_ff <= emit_step || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  desc_ff     <= q_head;
                  idx_ff      <= '0;
                  pos_ff      <= '0;
                  comp_ff     <= '0;
                  sum_ff      <= '0;
                  mismatch_ff <= 1'b0;
                  if (q_head.force_clear) prev_len_ff <= '0;
                  if (!q_head.empty)
                     state_ff <= (eff_prev == len_of(q_head.kind)) ? ST_CMP : ST_EMIT;
               end
            end
            ST_CMP: begin
               cmp_byte_ff <= gen_byte;
               mismatch_ff <= mismatch_ff | cmp_miss;
               idx_ff      <= idx_ff + 1'b1;
               sum_ff      <= sum_ff + gen_byte;
               if (idx_ff > IDX_BRIGHT) begin
                  comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
                  if (comp_ff == 2'd2) pos_ff <= pos_ff + 1'b1;
               end
               if (at_last) state_ff <= ST_CMP_END;
            end
            ST_CMP_END: begin
               idx_ff   <= '0;
               pos_ff   <= '0;
               comp_ff  <= '0;
               sum_ff   <= '0;
               state_ff <= (mismatch_ff || cmp_miss) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (emit_step) begin
                  rsp_byte_ff  <= gen_byte;
                  rsp_last_ff  <= at_last;
                  idx_ff       <= idx_ff + 1'b1;
                  sum_ff       <= sum_ff + gen_byte;
                  if (idx_ff > IDX_BRIGHT) begin
                     comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
                     if (comp_ff == 2'd2) pos_ff <= pos_ff + 1'b1;
                  end
                  if (at_last) begin
                     prev_len_ff <= frame_len;
                     state_ff    <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;

`ifndef SYNTHESIS
   a_word_only_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("Output word loaded outside the emit pass.");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP || state_ff == ST_EMIT) |-> (LEN_W'(idx_ff) < frame_len))
      else $error("Byte index ran past the frame length.");

   a_emit_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT ##1 state_ff == ST_IDLE) |-> (rsp_valid_ff && rsp_last_ff))
      else $error("Emit pass ended without loading the checksum word.");

   a_stored_len_legal: assert property (@(posedge clock) disable iff (reset)
      (prev_len_ff == '0 || prev_len_ff == LEN_RAINBOW || prev_len_ff == LEN_SOLID ||
       prev_len_ff == LEN_BREATH))
      else $error("Stored frame length is not a frame length.");
`endif

endmodule

// ----- sv/led_mcu_frame_builder.sv -----
// Top level of the LED controller frame builder: front end, descriptor queue and sequencer.
//
//   channel   ports                        handshake
//   request   req_*  (one commit request)  req_valid / req_ready
//   response  rsp_*  (one frame byte)      rsp_valid / rsp_ready
//   config    csr_*  (register write)      csr_we, no wait
//
// A frame has n bytes: 6 for rainbow, 3 + 6*BANK_POSITIONS for solid, 3 + 3*LED_POSITIONS for
// breath (51 at the default sizes). One shared byte generator and the single-port frame memory
// set the order of work: take a descriptor, run a compare pass when the stored frame has the
// same length, then an emit pass, which waits on rsp_ready, if the lengths differ or the
// compare found a difference; no new request is taken meanwhile. Reset clears the configuration
// to two zones with the right bank first and marks the stored frame invalid. The queue holds
// two requests, so the front takes up to two words while the sequencer is stalled on rsp_ready.
module led_mcu_frame_builder #(
   parameter int BANK_POSITIONS = lfb_pkg::BANK_POSITIONS_DEF,
   parameter int LED_POSITIONS  = lfb_pkg::LED_POSITIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [23:0]                     req_zone0_color,
   input  logic [3:0]                      req_zone0_effect,
   input  logic [12:0]                     req_zone0_speed,
   input  logic [6:0]                      req_zone0_brightness,
   input  logic [23:0]                     req_zone1_color,
   input  logic [6:0]                      req_zone1_brightness,
   input  logic                            req_force_resend,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_frame_byte,
   output logic                            rsp_last_byte
);
   import lfb_pkg::*;

   lfb_desc_type front_desc;
   lfb_desc_type q_head;
   logic         q_full;
   logic         q_valid;
   logic         q_pop;

   assign req_ready = !q_full;

   lfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .zone0_color      (req_zone0_color),
      .zone0_effect     (req_zone0_effect),
      .zone0_speed      (req_zone0_speed),
      .zone0_brightness (req_zone0_brightness),
      .zone1_color      (req_zone1_color),
      .zone1_brightness (req_zone1_brightness),
      .force_resend     (req_force_resend),
      .desc             (front_desc)
   );

   lfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_desc (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   lfb_back #(
      .BANK_POSITIONS (BANK_POSITIONS),
      .LED_POSITIONS  (LED_POSITIONS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
